// ===== rtl/ica_pkg.sv =====
// Package: widths, command and status codes, sequencer states for the calculator ALU.
`default_nettype none
package ica_pkg;
    localparam int DataWidth = 32;
    localparam int CntWidth  = $clog2(DataWidth + 1);

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0, CMD_SUB = 3'd1, CMD_MUL = 3'd2, CMD_DIV = 3'd3,
        CMD_POW = 3'd4, CMD_MOD = 3'd5, CMD_SQRT = 3'd6, CMD_INV = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_DIV0 = 3'd1, ST_OVF = 3'd2, ST_NEGROOT = 3'd3, ST_INVALID = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_DIV, S_SQRT, S_POW_SQ, S_POW_MUL, S_OUT
    } t_state;

    typedef struct packed {
        logic [DataWidth-1:0] result;
        t_status              status;
        logic                 last;
    } t_res;

    typedef struct packed {
        t_cmd                 command;
        logic [DataWidth-1:0] operand_a;
        logic [DataWidth-1:0] operand_b;
    } t_req;
endpackage
`default_nettype wire

// ===== rtl/ica_if.sv =====
// Valid/ready stream interfaces for requests and results.
`default_nettype none
interface ica_req_if;
    logic          valid;
    logic          ready;
    ica_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ica_res_if;
    logic          valid;
    logic          ready;
    ica_pkg::t_res payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/integer_calculator_alu.sv =====
// Integer calculator ALU: add, sub, mul, div, mod, power and dual square root.
// Channels: i_req (command, operand_a, operand_b) and o_res (result, status,
// last), both valid/ready; a request is taken when valid and ready are high.
// One request is in work at a time. Add, sub, invalid, divide by zero and the
// trivial powers go straight to the output state.
// Multiply, divide and mod run a bit-serial shift-add / restoring-divide loop
// of DataWidth iterations. Square root runs one root bit per cycle over
// DataWidth/2 iterations per operand, and sends two results, the second
// marked last. Power runs square-and-multiply over the exponent bits; each
// square and each multiply is a bit-serial multiply like the one above. The
// squared base leaves the signed range after log2(DataWidth) squarings, so
// power stops after at most log2(DataWidth) exponent bits. Zero or negative
// exponents and bases of magnitude 0 or 1 skip the loop.
// Results sit in an output register; the next request is taken the cycle after
// the last result is delivered, so a stalled receiver holds the block.
// Reset (synchronous, active low) returns the sequencer to idle and drops valid.
`default_nettype none
module integer_calculator_alu (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ica_req_if.sink      i_req,
    ica_res_if.source    o_res
);
    localparam int W = ica_pkg::DataWidth;
    localparam int CW = ica_pkg::CntWidth;

    ica_pkg::t_state r_state, n_state;
    ica_pkg::t_cmd   r_cmd;
    logic [W-1:0]    r_a, r_b;          // operands as received
    logic [W-1:0]    r_x, r_y;          // working magnitudes
    logic [2*W-1:0]  r_acc;             // product / remainder:quotient
    logic [W-1:0]    r_root;            // sqrt result
    logic [W+1:0]    r_rem;             // sqrt partial remainder
    logic [CW-1:0]   r_cnt;
    logic [W-1:0]    r_e;               // remaining exponent
    logic [2*W-1:0]  r_pr, r_base;      // power running product and square
    logic            r_neg, r_second, r_bovf;
    ica_pkg::t_res   r_out;
    logic            r_ov;

    logic            accept;
    logic [W-1:0]    ma, mb;
    logic [W-1:0]    lim;

    assign accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ica_pkg::S_IDLE) && !r_ov;
    assign o_res.valid = r_ov;
    assign o_res.payload = r_out;

    function automatic logic [W-1:0] f_mag(input logic [W-1:0] v);
        f_mag = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    assign ma = f_mag(i_req.payload.operand_a);
    assign mb = f_mag(i_req.payload.operand_b);
    assign lim = r_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ica_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ica_pkg::S_OUT;
                    case (i_req.payload.command)
                        ica_pkg::CMD_MUL: n_state = ica_pkg::S_MUL;
                        ica_pkg::CMD_DIV, ica_pkg::CMD_MOD:
                            if (mb != '0) n_state = ica_pkg::S_DIV;
                        ica_pkg::CMD_SQRT: n_state = ica_pkg::S_SQRT;
                        ica_pkg::CMD_POW:
                            if (!i_req.payload.operand_b[W-1] && i_req.payload.operand_b != '0
                                && ma > 1) n_state = ica_pkg::S_POW_MUL;
                        default: n_state = ica_pkg::S_OUT;
                    endcase
                end
            end
            ica_pkg::S_MUL, ica_pkg::S_DIV:
                if (r_cnt == CW'(W - 1)) n_state = ica_pkg::S_OUT;
            ica_pkg::S_SQRT:
                if (r_cnt == CW'(W/2 - 1)) n_state = ica_pkg::S_OUT;
            ica_pkg::S_POW_MUL:
                if (r_cnt == CW'(W - 1)) n_state = ica_pkg::S_POW_SQ;
            ica_pkg::S_POW_SQ:
                if (r_cnt == CW'(W - 1)) n_state = ica_pkg::S_OUT;
            ica_pkg::S_OUT: begin
                if (r_cmd == ica_pkg::CMD_SQRT && !r_second) n_state = ica_pkg::S_SQRT;
                else if (r_cmd == ica_pkg::CMD_POW && r_e != '0 && !r_bovf)
                    n_state = ica_pkg::S_POW_MUL;
                else n_state = ica_pkg::S_IDLE;
                if (r_ov && !o_res.ready) n_state = ica_pkg::S_OUT;
            end
            default: n_state = ica_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ica_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    // datapath: one bit per cycle in every loop
    logic [W:0]     d_diff;
    logic [W+1:0]   s_trial;
    logic [W+1:0]   s_rem2;
    logic           pw_done;
    assign d_diff  = {1'b0, r_acc[2*W-2:W-1]} - {1'b0, r_y};
    assign s_rem2  = {r_rem[W-1:0], r_x[W-1:W-2]};
    assign s_trial = s_rem2 - {r_root, 2'b01};
    assign pw_done = (r_e == '0) || r_bovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (o_res.ready) r_ov <= 1'b0;
            case (r_state)
                ica_pkg::S_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_req.payload.command;
                        r_a      <= i_req.payload.operand_a;
                        r_b      <= i_req.payload.operand_b;
                        r_cnt    <= '0;
                        r_second <= 1'b0;
                        r_acc    <= '0;
                        r_bovf   <= 1'b0;
                        case (i_req.payload.command)
                            ica_pkg::CMD_MUL: begin
                                r_x <= i_req.payload.operand_a;
                                r_y <= i_req.payload.operand_b;
                            end
                            ica_pkg::CMD_DIV, ica_pkg::CMD_MOD: begin
                                r_acc <= {{W{1'b0}}, ma};
                                r_y   <= mb;
                            end
                            ica_pkg::CMD_SQRT: begin
                                r_x    <= i_req.payload.operand_a;
                                r_root <= '0;
                                r_rem  <= '0;
                            end
                            ica_pkg::CMD_POW: begin
                                r_neg  <= i_req.payload.operand_a[W-1]
                                          && i_req.payload.operand_b[0];
                                // trivial powers carry no exponent into the loop
                                r_e    <= (n_state == ica_pkg::S_POW_MUL)
                                          ? i_req.payload.operand_b : '0;
                                r_pr   <= {{(2*W-1){1'b0}}, 1'b1};
                                r_base <= {{W{1'b0}}, ma};
                                r_x    <= ma;
                            end
                            default: r_x <= '0;
                        endcase
                    end
                end
                ica_pkg::S_MUL: begin
                    // shift-add, multiplier LSB first, accumulate upward
                    r_acc <= {r_acc[2*W-1:0]} + (r_x[0] ? ({{W{1'b0}}, r_y} << r_cnt) : '0);
                    r_x   <= r_x >> 1;
                    r_cnt <= r_cnt + 1'b1;
                end
                ica_pkg::S_DIV: begin
                    // restoring divide: acc = {rem, quotient}
                    if (!d_diff[W])
                        r_acc <= {d_diff[W-1:0], r_acc[W-2:0], 1'b1};
                    else
                        r_acc <= {r_acc[2*W-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                end
                ica_pkg::S_SQRT: begin
                    if (!s_trial[W+1]) begin
                        r_rem  <= s_trial;
                        r_root <= {r_root[W-2:0], 1'b1};
                    end else begin
                        r_rem  <= s_rem2;
                        r_root <= {r_root[W-2:0], 1'b0};
                    end
                    r_x   <= r_x << 2;
                    r_cnt <= r_cnt + 1'b1;
                end
                ica_pkg::S_POW_MUL: begin
                    // pr *= base when exponent LSB set (serial over base bits)
                    if (r_e[0] && r_x[0])
                        r_acc <= r_acc + (r_pr << r_cnt);
                    r_x   <= r_x >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) begin
                        r_cnt <= '0;
                        if (r_e[0]) begin
                            r_pr <= r_acc + ((r_x[0]) ? (r_pr << r_cnt) : '0);
                            if ((r_acc + ((r_x[0]) ? (r_pr << r_cnt) : '0)) > {{W{1'b0}}, lim})
                                r_bovf <= 1'b1;
                        end
                        r_acc <= '0;
                        r_x   <= r_base[W-1:0];
                        r_e   <= r_e >> 1;
                    end
                end
                ica_pkg::S_POW_SQ: begin
                    // base *= base, only needed while exponent bits remain
                    if (r_x[0])
                        r_acc <= r_acc + (r_base << r_cnt);
                    r_x   <= r_x >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) begin
                        r_cnt <= '0;
                        if (r_e != '0 && !r_bovf &&
                            (r_acc + (r_x[0] ? (r_base << r_cnt) : '0)) > {{W{1'b0}}, lim})
                            r_bovf <= 1'b1;
                        r_base <= r_acc + (r_x[0] ? (r_base << r_cnt) : '0);
                        r_x    <= r_acc[W-1:0] + (r_x[0] ? r_base[W-1:0] << r_cnt : '0);
                        r_acc  <= '0;
                    end
                end
                ica_pkg::S_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        if (!(r_cmd == ica_pkg::CMD_POW && !pw_done)) begin
                            r_ov <= 1'b1;
                            r_out.last   <= 1'b1;
                            r_out.status <= ica_pkg::ST_OK;
                            r_out.result <= '0;
                        end
                        case (r_cmd)
                            ica_pkg::CMD_ADD: r_out.result <= r_a + r_b;
                            ica_pkg::CMD_SUB: r_out.result <= r_a - r_b;
                            ica_pkg::CMD_MUL: r_out.result <= r_acc[W-1:0];
                            ica_pkg::CMD_DIV: begin
                                if (r_b == '0) r_out.status <= ica_pkg::ST_DIV0;
                                else if (r_a == {1'b1, {(W-1){1'b0}}} && r_b == '1)
                                    r_out.status <= ica_pkg::ST_OVF;
                                else if (r_a[W-1] ^ r_b[W-1])
                                    r_out.result <= ~r_acc[W-1:0] + 1'b1;
                                else r_out.result <= r_acc[W-1:0];
                            end
                            ica_pkg::CMD_MOD: begin
                                if (r_b == '0) r_out.status <= ica_pkg::ST_DIV0;
                                else if (r_a[W-1])
                                    r_out.result <= ~r_acc[2*W-1:W] + 1'b1;
                                else r_out.result <= r_acc[2*W-1:W];
                            end
                            ica_pkg::CMD_SQRT: begin
                                r_out.last <= r_second;
                                if ((r_second ? r_b[W-1] : r_a[W-1]))
                                    r_out.status <= ica_pkg::ST_NEGROOT;
                                else r_out.result <= r_root;
                                if (!r_second) begin
                                    r_second <= 1'b1;
                                    r_x      <= r_b;
                                    r_root   <= '0;
                                    r_rem    <= '0;
                                    r_cnt    <= '0;
                                end
                            end
                            ica_pkg::CMD_POW: begin
                                if (r_b[W-1]) begin
                                    if (r_a == {{(W-1){1'b0}}, 1'b1})
                                        r_out.result <= r_a;
                                    else if (r_a == '1)
                                        r_out.result <= r_b[0] ? '1 : {{(W-1){1'b0}}, 1'b1};
                                end else if (r_b == '0)
                                    r_out.result <= {{(W-1){1'b0}}, 1'b1};
                                else if (f_mag(r_a) <= {{(W-1){1'b0}}, 1'b1})
                                    r_out.result <= r_a[W-1] && !r_b[0] ? f_mag(r_a) : r_a;
                                else if (r_bovf) r_out.status <= ica_pkg::ST_OVF;
                                else r_out.result <= r_neg ? ~r_pr[W-1:0] + 1'b1
                                                          : r_pr[W-1:0];
                            end
                            default: r_out.status <= ica_pkg::ST_INVALID;
                        endcase
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/ica_checker.sv =====
// Port-level checker for the calculator ALU, bound to the top level.
`default_nettype none
module ica_checker (
    input wire          i_clk,
    input wire          i_rst_n,
    input wire          req_valid,
    input wire          req_ready,
    input wire          res_valid,
    input wire          res_ready,
    input wire ica_pkg::t_res res
);
    a_no_req_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !req_ready) else $error("request taken while result pending");
    a_zero_on_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && res.status != ica_pkg::ST_OK |-> res.result == '0)
        else $error("nonzero result with error status");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result dropped under stall");
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid) else $error("valid after reset");
endmodule

bind integer_calculator_alu ica_checker u_ica_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready), .res(o_res.payload)
);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the integer calculator ALU.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int NumRandom = 1400;
    localparam int IdleLimit = 20000;
    localparam int DrainCycles = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ica_req_if req_bus ();
    ica_res_if res_bus ();

    integer_calculator_alu DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_res   (res_bus.source)
    );

    always #10 i_clk = ~i_clk;

    ica_pkg::t_req pending_reqs[$];
    ica_pkg::t_res expected_results[$];
    int   mismatches = 0;
    int   send_idle_pct = 0;
    int   stall_pct = 0;
    bit   hold_send = 1'b0;
    bit   req_taken = 1'b0;
    int   quiet_cycles = 0;

    // Exact floor square root of a non-negative value.
    function automatic logic [31:0] floor_root(input logic [31:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem = {32'd0, v};
        root = 0;
        b = 64'd1 << 62;
        while (b > rem) b = b >> 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root[31:0];
    endfunction

    // Exact integer power; returns status, value via output argument.
    function automatic ica_pkg::t_status int_power(input logic signed [31:0] base,
                                                   input logic signed [31:0] expo,
                                                   output logic [31:0] val);
        logic [63:0] mag;
        logic [63:0] acc;
        logic [63:0] lim;
        logic        neg;
        neg = base[31] && expo[0];
        mag = base[31] ? 64'(-64'(base)) : 64'(base);
        val = 0;
        if (expo < 0) begin
            if (base == 1) val = 1;
            else if (base == -1) val = expo[0] ? 32'hFFFF_FFFF : 32'd1;
            return ica_pkg::ST_OK;
        end
        if (expo == 0) begin
            val = 1;
            return ica_pkg::ST_OK;
        end
        if (mag <= 1) begin
            val = neg ? 32'(-mag) : 32'(mag);
            return ica_pkg::ST_OK;
        end
        if (expo >= 64) return ica_pkg::ST_OVF;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        acc = 1;
        for (int i = 0; i < expo; i++) begin
            if (acc > lim / mag) return ica_pkg::ST_OVF;
            acc = acc * mag;
        end
        val = neg ? 32'(-acc) : 32'(acc);
        return ica_pkg::ST_OK;
    endfunction

    // Compute the results a request produces and queue them.
    task automatic predict_results(input ica_pkg::t_req rq);
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] r;
        ica_pkg::t_status st;
        a = rq.operand_a;
        b = rq.operand_b;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        r = 0;
        st = ica_pkg::ST_OK;
        case (rq.command)
            ica_pkg::CMD_ADD: r = a + b;
            ica_pkg::CMD_SUB: r = a - b;
            ica_pkg::CMD_MUL: r = a * b;
            ica_pkg::CMD_DIV: begin
                if (b == 0) st = ica_pkg::ST_DIV0;
                else if (a == 32'h8000_0000 && b == -1) st = ica_pkg::ST_OVF;
                else begin
                    r = ma / mb;
                    if (a[31] != b[31]) r = -r;
                end
            end
            ica_pkg::CMD_POW: st = int_power(a, b, r);
            ica_pkg::CMD_MOD: begin
                if (b == 0) st = ica_pkg::ST_DIV0;
                else begin
                    r = ma % mb;
                    if (a[31]) r = -r;
                end
            end
            ica_pkg::CMD_SQRT: begin
                expected_results.push_back(a[31]
                    ? ica_pkg::t_res'{0, ica_pkg::ST_NEGROOT, 1'b0}
                    : ica_pkg::t_res'{floor_root(a), ica_pkg::ST_OK, 1'b0});
                expected_results.push_back(b[31]
                    ? ica_pkg::t_res'{0, ica_pkg::ST_NEGROOT, 1'b1}
                    : ica_pkg::t_res'{floor_root(b), ica_pkg::ST_OK, 1'b1});
                return;
            end
            default: st = ica_pkg::ST_INVALID;
        endcase
        if (st != ica_pkg::ST_OK) r = 0;
        expected_results.push_back(ica_pkg::t_res'{r, st, 1'b1});
    endtask

    // Driver: inputs change on the falling edge; a new request once the last is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_taken) begin
            if (req_taken) void'(pending_reqs.pop_front());
            req_taken = 1'b0;
            if (pending_reqs.size() > 0 && !hold_send &&
                $urandom_range(99) >= send_idle_pct) begin
                req_bus.valid <= 1'b1;
                req_bus.payload <= pending_reqs[0];
            end else begin
                req_bus.valid <= 1'b0;
                req_bus.payload <= ica_pkg::t_req'($urandom);
            end
        end
        res_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: requests and results sampled on the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && req_bus.valid && req_bus.ready) begin
            predict_results(req_bus.payload);
            req_taken = 1'b1;
        end
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", res_bus.payload);
            end else begin
                ica_pkg::t_res exp_r;
                exp_r = expected_results.pop_front();
                if (res_bus.payload.result !== exp_r.result ||
                    res_bus.payload.status !== exp_r.status ||
                    res_bus.payload.last !== exp_r.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 exp_r.result, exp_r.status, exp_r.last,
                                 res_bus.payload.result, res_bus.payload.status,
                                 res_bus.payload.last);
                end
            end
        end
    end

    // Watchdog on cycles with no handshake.
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return 32'($signed($urandom_range(20)) - 10);
            1: return 32'h8000_0000 ^ 32'($urandom_range(1));
            2: return 32'h7FFF_FFFF - 32'($urandom_range(1));
            3: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(input ica_pkg::t_cmd c, input logic [31:0] a,
                           input logic [31:0] b);
        pending_reqs.push_back(ica_pkg::t_req'{c, a, b});
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_bus.valid || expected_results.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        ica_pkg::t_cmd c;
        req_bus.valid = 1'b0;
        req_bus.payload = '0;
        res_bus.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases.
        add_req(ica_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1);
        add_req(ica_pkg::CMD_SUB, 32'h8000_0000, 32'd1);
        add_req(ica_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h8000_0000);
        add_req(ica_pkg::CMD_MUL, 32'h0001_0000, 32'h0001_0000);
        add_req(ica_pkg::CMD_DIV, 32'd7, 32'd0);
        add_req(ica_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        add_req(ica_pkg::CMD_DIV, -32'sd7, 32'd2);
        add_req(ica_pkg::CMD_MOD, 32'd5, 32'd0);
        add_req(ica_pkg::CMD_MOD, 32'h8000_0000, 32'hFFFF_FFFF);
        add_req(ica_pkg::CMD_MOD, -32'sd7, 32'd3);
        add_req(ica_pkg::CMD_POW, 32'd1, -32'sd5);
        add_req(ica_pkg::CMD_POW, -32'sd1, -32'sd3);
        add_req(ica_pkg::CMD_POW, -32'sd1, -32'sd4);
        add_req(ica_pkg::CMD_POW, 32'd0, -32'sd1);
        add_req(ica_pkg::CMD_POW, 32'd0, 32'd0);
        add_req(ica_pkg::CMD_POW, -32'sd2, 32'd31);
        add_req(ica_pkg::CMD_POW, 32'd2, 32'd31);
        add_req(ica_pkg::CMD_POW, 32'd3, 32'd19);
        add_req(ica_pkg::CMD_POW, 32'd2, 32'h7FFF_FFFF);
        add_req(ica_pkg::CMD_SQRT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_req(ica_pkg::CMD_SQRT, 32'h8000_0000, 32'd0);
        add_req(ica_pkg::CMD_INV, 32'hFFFF_FFFF, 32'h1234_5678);
        wait_drained();

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin send_idle_pct = 51; stall_pct = 0; end
                2: begin send_idle_pct = 0; stall_pct = 51; end
                3: begin send_idle_pct = 24; stall_pct = 24; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int i = 0; i < NumRandom / 5; i++) begin
                c = ica_pkg::t_cmd'($urandom_range(7));
                a = rand_operand();
                b = rand_operand();
                // keep power mostly to small exponents so the run stays short
                if (c == ica_pkg::CMD_POW && $urandom_range(3) != 0) begin
                    a = 32'($signed($urandom_range(40)) - 20);
                    b = 32'($signed($urandom_range(36)) - 3);
                end
                add_req(c, a, b);
                if (i == 100) begin
                    // let the block empty out before going on
                    wait_drained();
                    hold_send = 1'b1;
                    repeat ($urandom_range(20)) @(posedge i_clk);
                    hold_send = 1'b0;
                end
            end
            wait_drained();
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
